[rtl/bsr_pkg.sv]
// Shared constants, types and helpers of the byte stream reassembler.
package bsr_pkg;

	// Ring size in bytes; the window spans read point to read point plus this.
	localparam int CAPACITY = 1024;
	localparam int AW       = $clog2(CAPACITY);
	localparam int OFF_W    = AW + 1;
	localparam int PEND_W   = $clog2(CAPACITY + 1);

	// Fixed field widths of the stream ports.
	localparam int POS_W    = 32;
	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 11;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 56;
	localparam int USER_W   = 2;

	// Request kinds carried in the action field.
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// Address source for the valid bitmap memory.
	typedef enum logic [1:0] {
		SEL_CLR  = 2'd0,
		SEL_PUSH = 2'd1,
		SEL_SCAN = 2'd2,
		SEL_HEAD = 2'd3
	} addr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load;
		logic      clr_step;
		logic      vrd;
		logic      vwr;
		logic      vbit;
		addr_sel_t asel;
		logic      bwr;
		logic      brd;
		logic      store;
		logic      advance;
		logic      pop;
		logic      result;
		logic      res_read;
		logic      res_acc;
	} bsr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic is_read;
		logic read_ok;
		logic push_ok;
		logic slot_free;
		logic scan_room;
		logic vbit_rd;
		logic out_free;
	} bsr_status_t;

	// Ring slot of a window offset below the capacity.
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
	                                          input logic [OFF_W-1:0] off);
		logic [OFF_W-1:0] sum;
		sum = {1'b0, head} + off;
		if (sum >= OFF_W'(CAPACITY)) begin
			sum = sum - OFF_W'(CAPACITY);
		end
		return sum[AW-1:0];
	endfunction

endpackage

[rtl/bsr_ram.sv]
// Generic single-write, single-read memory with a registered read port.
module bsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds between reads.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/bsr_ctrl.sv]
// Controller state machine of the byte stream reassembler.
module bsr_ctrl
	import bsr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  bsr_status_t st,
	output bsr_cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_INIT = 7'b0000001,
		ST_IDLE = 7'b0000010,
		ST_EVAL = 7'b0000100,
		ST_PCHK = 7'b0001000,
		ST_SCAN = 7'b0010000,
		ST_SCHK = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   rd_q;
	logic   acc_q;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.asel = SEL_CLR;
		in_ready = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.vwr      = 1'b1;
				cmd.vbit     = 1'b0;
				cmd.asel     = SEL_CLR;
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (st.is_read) begin
					if (st.read_ok) begin
						cmd.brd  = 1'b1;
						cmd.pop  = 1'b1;
						cmd.vwr  = 1'b1;
						cmd.vbit = 1'b0;
						cmd.asel = SEL_HEAD;
					end
					state_d = ST_DONE;
				end else if (st.push_ok) begin
					cmd.vrd  = 1'b1;
					cmd.asel = SEL_PUSH;
					state_d  = ST_PCHK;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_PCHK: begin
				if (st.slot_free) begin
					cmd.vwr   = 1'b1;
					cmd.vbit  = 1'b1;
					cmd.asel  = SEL_PUSH;
					cmd.bwr   = 1'b1;
					cmd.store = 1'b1;
				end
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (st.scan_room) begin
					cmd.vrd  = 1'b1;
					cmd.asel = SEL_SCAN;
					state_d  = ST_SCHK;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCHK: begin
				if (st.vbit_rd) begin
					cmd.advance = 1'b1;
					state_d     = ST_SCAN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.result   = 1'b1;
					cmd.res_read = rd_q;
					cmd.res_acc  = acc_q;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Outcome flags of the current request, settled in the evaluate step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			acc_q <= 1'b0;
		end else if (state_q == ST_EVAL) begin
			rd_q  <= st.is_read & st.read_ok;
			acc_q <= ~st.is_read & st.push_ok;
		end
	end

	// Only one request is in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !in_ready)
		else $error("new request taken while one is in flight");

	// A scan step only advances on a bitmap read issued the cycle before.
	a_advance_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> $past(cmd.vrd))
		else $error("assembled point advanced without a bitmap read");

	// A byte is stored only after its slot was checked.
	a_store_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bwr |-> $past(cmd.vrd) && $past(cmd.asel) == SEL_PUSH)
		else $error("byte stored without a slot check");

endmodule

[rtl/bsr_datapath.sv]
// Datapath of the byte stream reassembler: pointers, ring memories, result register.
module bsr_datapath
	import bsr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  bsr_cmd_t            cmd,
	output bsr_status_t         st,
	input  logic [S_DATA_W-1:0] in_data,
	input  logic [USER_W-1:0]   in_user,
	input  logic                in_last,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [M_DATA_W-1:0] out_data,
	output logic [USER_W-1:0]   out_user,
	output logic                out_last
);

	logic [POS_W-1:0]  asm_q;
	logic [POS_W-1:0]  rdp_q;
	logic [AW-1:0]     head_q;
	logic [OFF_W-1:0]  aoff_q;
	logic [PEND_W-1:0] pend_q;
	logic              end_known_q;
	logic [POS_W-1:0]  end_pos_q;
	logic [AW-1:0]     clr_q;
	logic              act_q;
	logic              has_q;
	logic [POS_W-1:0]  off_q;
	logic [BYTE_W-1:0] byte_q;
	logic              out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;
	logic [USER_W-1:0] out_user_q;
	logic              out_last_q;

	logic [POS_W-1:0]  in_idx;
	logic [BYTE_W-1:0] in_byte;
	logic              in_act;
	logic              in_has;
	logic [AW-1:0]     push_slot;
	logic [AW-1:0]     scan_slot;
	logic [AW-1:0]     vaddr;
	logic              vrdata;
	logic [BYTE_W-1:0] brdata;
	logic [BYTE_W-1:0] res_byte;
	logic              ended;

	assign in_idx  = in_data[POS_W-1:0];
	assign in_byte = in_data[POS_W+BYTE_W-1:POS_W];
	assign in_act  = in_user[0];
	assign in_has  = in_user[1];

	// Ring slots of the pushed byte and of the assembled point.
	assign push_slot = slot_of(head_q, off_q[OFF_W-1:0]);
	assign scan_slot = slot_of(head_q, aoff_q);

	// Bitmap address selection.
	always_comb begin
		case (cmd.asel)
			SEL_CLR:  vaddr = clr_q;
			SEL_PUSH: vaddr = push_slot;
			SEL_SCAN: vaddr = scan_slot;
			SEL_HEAD: vaddr = head_q;
			default:  vaddr = clr_q;
		endcase
	end

	// Valid bitmap of the ring.
	bsr_ram #(
		.WIDTH (1),
		.DEPTH (CAPACITY)
	) u_valid_ram (
		.clk   (clk),
		.we    (cmd.vwr),
		.waddr (vaddr),
		.wdata (cmd.vbit),
		.re    (cmd.vrd),
		.raddr (vaddr),
		.rdata (vrdata)
	);

	// Byte store of the ring.
	bsr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (CAPACITY)
	) u_byte_ram (
		.clk   (clk),
		.we    (cmd.bwr),
		.waddr (push_slot),
		.wdata (byte_q),
		.re    (cmd.brd),
		.raddr (head_q),
		.rdata (brdata)
	);

	// Request capture; the window offset is taken against the read point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= ACT_PUSH;
			has_q  <= 1'b0;
			off_q  <= '0;
			byte_q <= '0;
		end else if (cmd.load) begin
			act_q  <= in_act;
			has_q  <= in_has;
			off_q  <= in_idx - rdp_q;
			byte_q <= in_byte;
		end
	end

	// End mark, recorded on any push.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_known_q <= 1'b0;
			end_pos_q   <= '0;
		end else if (cmd.load && in_act == ACT_PUSH && in_last) begin
			end_known_q <= 1'b1;
			end_pos_q   <= in_idx + POS_W'(in_has);
		end
	end

	// Stream pointers, ring head and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asm_q  <= '0;
			rdp_q  <= '0;
			head_q <= '0;
			aoff_q <= '0;
			pend_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.store) begin
				pend_q <= pend_q + PEND_W'(1);
			end
			if (cmd.advance) begin
				asm_q  <= asm_q + POS_W'(1);
				aoff_q <= aoff_q + OFF_W'(1);
				if (pend_q != '0) begin
					pend_q <= pend_q - PEND_W'(1);
				end
			end
			if (cmd.pop) begin
				rdp_q  <= rdp_q + POS_W'(1);
				aoff_q <= aoff_q - OFF_W'(1);
				if (head_q == AW'(CAPACITY - 1)) begin
					head_q <= '0;
				end else begin
					head_q <= head_q + AW'(1);
				end
			end
		end
	end

	// Status toward the controller.
	always_comb begin
		st.clr_last  = (clr_q == AW'(CAPACITY - 1));
		st.is_read   = (act_q == ACT_READ);
		st.read_ok   = (aoff_q != '0);
		st.push_ok   = has_q && (off_q >= POS_W'(aoff_q)) && (off_q < POS_W'(CAPACITY));
		st.slot_free = ~vrdata;
		st.scan_room = (aoff_q < OFF_W'(CAPACITY));
		st.vbit_rd   = vrdata;
		st.out_free  = ~out_valid_q | out_ready;
	end

	assign res_byte = cmd.res_read ? brdata : '0;
	assign ended    = end_known_q && (asm_q == end_pos_q);

	// Result register toward the output stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result) begin
			out_data_q <= {{(M_DATA_W - COUNT_W - POS_W - BYTE_W){1'b0}},
			               COUNT_W'(pend_q), asm_q, res_byte};
			out_user_q <= {cmd.res_acc, cmd.res_read};
			out_last_q <= ended;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;
	assign out_last  = out_last_q;

	// The assembled offset tracks the pointer distance.
	a_aoff_matches: assert property (@(posedge clk) disable iff (!arst_n)
		aoff_q == OFF_W'(asm_q - rdp_q) && aoff_q <= OFF_W'(CAPACITY))
		else $error("assembled offset out of step with pointers");

	// A pop only happens with an assembled byte waiting.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> aoff_q != '0 && !cmd.advance)
		else $error("pop with nothing assembled");

endmodule

[rtl/byte_stream_reassembler.sv]
// Flow: a read, or a push with no byte in the window, is evaluated and then written to
// the result register; a push in the window checks and stores its slot, then scans the
// bitmap, advancing per byte assembled, until a gap or a full window. The next request
// is taken only after the result is written, and a result held back by m_tready stalls the input.
// Reset: arst_n clears all pointers, then a clearing pass zeroes the valid
// bitmap one slot a cycle while s_tready stays low.
module byte_stream_reassembler
	import bsr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // stream_index[31:0], data_byte[39:32]
	input  logic [USER_W-1:0]   s_tuser,  // action[0], has_byte[1]
	input  logic                s_tlast,  // end_mark
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // read_byte[7:0], assembled_position[39:8],
	                                      // unassembled_count[50:40], zero pad
	output logic [USER_W-1:0]   m_tuser,  // read_valid[0], byte_accepted[1]
	output logic                m_tlast   // end_reached
);

	bsr_cmd_t    cmd;
	bsr_status_t st;

	// Sequencer for each request.
	bsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// Ring storage, pointers and result register.
	bsr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

[test/reassembly_checker.sv]
// Checker for the byte stream reassembler: predicts every result and compares it.
`timescale 1ns / 100ps

module reassembly_checker
	import bsr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // stream_index[31:0], data_byte[39:32]
	input  logic [USER_W-1:0]   s_tuser,  // action[0], has_byte[1]
	input  logic                s_tlast,  // end_mark
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,  // read_byte[7:0], assembled_position[39:8],
	                                      // unassembled_count[50:40], zero pad
	input  logic [USER_W-1:0]   m_tuser,  // read_valid[0], byte_accepted[1]
	input  logic                m_tlast,  // end_reached
	output int                  mismatches,
	output int                  results_owed,
	output logic [POS_W-1:0]    read_pos,
	output logic [POS_W-1:0]    asm_pos
);

	// One result as the block should produce it.
	typedef struct packed {
		logic               read_valid;
		logic [BYTE_W-1:0]  read_byte;
		logic               accepted;
		logic [POS_W-1:0]   position;
		logic [COUNT_W-1:0] count;
		logic               ended;
	} reassembly_result_t;

	// Shadow copy of the ring, its bitmap and the stream pointers.
	logic [BYTE_W-1:0]  ring_data [CAPACITY];
	bit                 ring_full [CAPACITY];
	logic [POS_W-1:0]   asm_pt;
	logic [POS_W-1:0]   rd_pt;
	logic [POS_W-1:0]   end_pt;
	bit                 end_seen;
	int unsigned        pend;
	int                 head;
	int                 n_results;

	reassembly_result_t owed_results [$];

	initial mismatches = 0;

	// Print one line per mismatch (the first few only) and count them all.
	task automatic report_mismatch(input string what, input logic [POS_W-1:0] got,
	                               input logic [POS_W-1:0] want);
		if (mismatches < 24) begin
			$display("mismatch %s at result %0d: got 0x%0h, expected 0x%0h",
			         what, n_results, got, want);
		end
		mismatches++;
	endtask

	// Apply one request to the shadow state and work out its result.
	task automatic reassemble(input logic act, input logic [POS_W-1:0] idx,
	                          input logic [BYTE_W-1:0] dbyte, input logic has,
	                          input logic endm, output reassembly_result_t res);
		logic [POS_W-1:0] off;
		logic [POS_W-1:0] asm_off;
		int               slot;
		res = '0;
		if (act == ACT_READ) begin
			// Pop the oldest assembled byte, if any.
			if (rd_pt != asm_pt) begin
				res.read_valid = 1'b1;
				res.read_byte  = ring_data[head];
				ring_full[head] = 1'b0;
				rd_pt = rd_pt + 1;
				head = (head + 1) % CAPACITY;
			end
		end else begin
			if (has) begin
				// Window runs from the assembled point up to read point plus capacity.
				off     = idx - rd_pt;
				asm_off = asm_pt - rd_pt;
				if (off >= asm_off && off < CAPACITY) begin
					slot = int'((head + off) % CAPACITY);
					res.accepted = 1'b1;
					if (!ring_full[slot]) begin
						ring_full[slot] = 1'b1;
						ring_data[slot] = dbyte;
						pend++;
					end
					while ((asm_pt - rd_pt) < CAPACITY &&
					       ring_full[(head + (asm_pt - rd_pt)) % CAPACITY]) begin
						asm_pt = asm_pt + 1;
						if (pend > 0) begin
							pend--;
						end
					end
				end
			end
			// The end mark counts on any push, in the window or not.
			if (endm) begin
				end_seen = 1'b1;
				end_pt   = idx + has;
			end
		end
		res.position = asm_pt;
		res.count    = pend[COUNT_W-1:0];
		res.ended    = end_seen && (asm_pt == end_pt);
	endtask

	// Compare one accepted result with the oldest expectation.
	task automatic check_result();
		reassembly_result_t want;
		n_results++;
		if (owed_results.size() == 0) begin
			report_mismatch("result with no request waiting", 1, 0);
		end else begin
			want = owed_results.pop_front();
			if (m_tuser[0] !== want.read_valid)
				report_mismatch("read_valid", POS_W'(m_tuser[0]), POS_W'(want.read_valid));
			if (m_tdata[7:0] !== want.read_byte)
				report_mismatch("read_byte", POS_W'(m_tdata[7:0]), POS_W'(want.read_byte));
			if (m_tuser[1] !== want.accepted)
				report_mismatch("byte_accepted", POS_W'(m_tuser[1]), POS_W'(want.accepted));
			if (m_tdata[39:8] !== want.position)
				report_mismatch("assembled_position", m_tdata[39:8], want.position);
			if (m_tdata[50:40] !== want.count)
				report_mismatch("unassembled_count", POS_W'(m_tdata[50:40]),
				                POS_W'(want.count));
			if (m_tlast !== want.ended)
				report_mismatch("end_reached", POS_W'(m_tlast), POS_W'(want.ended));
		end
	endtask

	// Watch both channels; results are checked before the new request is queued.
	always @(posedge clk or negedge arst_n) begin
		reassembly_result_t res;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				ring_full[i] = 1'b0;
				ring_data[i] = '0;
			end
			asm_pt   = '0;
			rd_pt    = '0;
			end_pt   = '0;
			end_seen = 1'b0;
			pend     = 0;
			head     = 0;
			n_results = 0;
			owed_results.delete();
			results_owed <= 0;
			read_pos     <= '0;
			asm_pos      <= '0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result();
			end
			if (s_tvalid && s_tready) begin
				reassemble(s_tuser[0], s_tdata[31:0], s_tdata[39:32], s_tuser[1], s_tlast,
				           res);
				owed_results.push_back(res);
			end
			results_owed <= owed_results.size();
			read_pos     <= rd_pt;
			asm_pos      <= asm_pt;
		end
	end

endmodule

[test/tb_byte_stream_reassembler.sv]
// Testbench top for the byte stream reassembler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_byte_stream_reassembler;

	import bsr_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int MIXED_ITEMS  = 800;
	localparam int DRAIN_READS  = 64;
	localparam int SETTLE_TICKS = 64;

	// Orders in which the bytes of one segment are pushed.
	typedef enum int {
		ORD_ASCENDING,
		ORD_SHUFFLED,
		ORD_HALVES_SWAPPED,
		ORD_DESCENDING
	} push_order_t;

	// Receiver behavior, changed every so often.
	typedef enum int {
		RX_OPEN,
		RX_CHOPPY,
		RX_CHOKED
	} rx_mode_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;  // stream_index[31:0], data_byte[39:32]
	logic [USER_W-1:0]   s_tuser  = '0;  // action[0], has_byte[1]
	logic                s_tlast  = 1'b0;  // end_mark
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;  // read_byte[7:0], assembled_position[39:8],
	                               // unassembled_count[50:40], zero pad
	logic [USER_W-1:0]   m_tuser;  // read_valid[0], byte_accepted[1]
	logic                m_tlast;  // end_reached

	int               mismatches;
	int               results_owed;
	logic [POS_W-1:0] read_pos;
	logic [POS_W-1:0] asm_pos;

	int unsigned      cycles = 0;
	int               burst_left = 0;
	int               n_sent = 0;
	int               n_reads = 0;
	int               mixed_start;
	rx_mode_t         rx_mode = RX_OPEN;
	int               rx_left = 0;
	logic [BYTE_W-1:0] salt;
	logic [POS_W-1:0] wr_head;
	logic [POS_W-1:0] win_base;
	logic [POS_W-1:0] fill_top;
	logic [POS_W-1:0] fill_bot;
	logic [POS_W-1:0] blk_len;
	int               roll;

	byte_stream_reassembler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	reassembly_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.mismatches   (mismatches),
		.results_owed (results_owed),
		.read_pos     (read_pos),
		.asm_pos      (asm_pos)
	);

	// Free-running clock, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL byte_stream_reassembler");
			$finish;
		end
	end

	// Receiver stalls: open, choppy or mostly blocked, each for a random stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 2));
				rx_left <= $urandom_range(8, 200);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_OPEN: begin
					m_tready <= 1'b1;
				end
				RX_CHOPPY: begin
					m_tready <= 1'($urandom_range(0, 1));
				end
				default: begin
					m_tready <= ($urandom_range(0, 3) == 0);
				end
			endcase
		end
	end

	// Byte content of the stream at a position.
	function automatic logic [BYTE_W-1:0] stream_byte(input logic [POS_W-1:0] pos);
		return pos[7:0] ^ {pos[12:8], pos[15:13]} ^ salt;
	endfunction

	// Offer one request and hold it until taken; gaps follow each burst.
	task automatic send_request(input logic act, input logic [POS_W-1:0] idx,
	                            input logic [BYTE_W-1:0] dbyte, input logic has,
	                            input logic endm);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {dbyte, idx};
		s_tuser  <= {has, act};
		s_tlast  <= endm;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_sent++;
		if (act == ACT_READ) begin
			n_reads++;
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 24);
		end
	endtask

	// A read request with random values in the fields it ignores.
	task automatic send_read();
		send_request(ACT_READ, $urandom, BYTE_W'($urandom), 1'($urandom_range(0, 1)),
		             1'($urandom_range(0, 1)));
	endtask

	task automatic send_push(input logic [POS_W-1:0] idx, input logic [BYTE_W-1:0] dbyte);
		send_request(ACT_PUSH, idx, dbyte, 1'b1, 1'b0);
	endtask

	// Hold off the sender until every expected result has come back.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
	endtask

	// Push one segment of the stream in the given order; a few bytes carry odd data.
	task automatic push_segment(input logic [POS_W-1:0] first, input int len,
	                            input push_order_t order);
		logic [POS_W-1:0] seq [$];
		logic [POS_W-1:0] tmp;
		int               j;
		int               half;
		for (int i = 0; i < len; i++) begin
			seq.push_back(first + i);
		end
		case (order)
			ORD_SHUFFLED: begin
				for (int i = len - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp = seq[i];
					seq[i] = seq[j];
					seq[j] = tmp;
				end
			end
			ORD_HALVES_SWAPPED: begin
				half = len / 2;
				for (int i = 0; i < half; i++) begin
					seq.push_back(seq.pop_front());
				end
			end
			ORD_DESCENDING: begin
				seq.reverse();
			end
			default: begin
			end
		endcase
		foreach (seq[i]) begin
			if ($urandom_range(0, 99) < 6) begin
				send_push(seq[i], BYTE_W'($urandom));
			end else begin
				send_push(seq[i], stream_byte(seq[i]));
			end
		end
	endtask

	initial begin
		salt = BYTE_W'($urandom);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests: window edges, overlap, end marks, empty reads.
		send_read();
		send_push(32'hFFFF_FFFF, 8'hFF);
		send_push(CAPACITY, 8'h81);
		send_push(CAPACITY - 1, 8'h00);
		send_push(32'd1, 8'hA5);
		send_push(32'd1, 8'h5A);
		send_push(32'd0, 8'h3C);
		send_request(ACT_PUSH, 32'd2, 8'h00, 1'b0, 1'b1);
		send_push(32'd0, 8'h77);
		send_request(ACT_PUSH, 32'd3, 8'hFF, 1'b0, 1'b0);
		send_read();
		send_read();
		send_request(ACT_READ, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1);
		send_request(ACT_PUSH, 32'd5, 8'hC3, 1'b1, 1'b1);
		send_request(ACT_PUSH, 32'd0, 8'h00, 1'b0, 1'b1);
		send_push(32'd4, 8'h0F);
		send_push(32'd3, 8'hF0);
		send_push(32'd2, 8'h11);
		send_request(ACT_PUSH, 32'd6, 8'h00, 1'b0, 1'b1);
		send_push(CAPACITY + 1, 8'h96);
		send_push(CAPACITY + 2, 8'h69);
		send_read();
		wait_idle();

		// Mixed traffic: segments in and out of order, reads, and noise.
		wr_head = asm_pos;
		mixed_start = n_sent;
		while (n_sent - mixed_start < MIXED_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 14) begin
				case ($urandom_range(0, 5))
					0: send_request(ACT_PUSH, $urandom, BYTE_W'($urandom),
					                1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
					1: send_push(asm_pos - $urandom_range(1, 40), BYTE_W'($urandom));
					2: send_push(read_pos + CAPACITY - 1 + $urandom_range(0, 2),
					             BYTE_W'($urandom));
					3: send_request(ACT_PUSH, wr_head + $urandom_range(0, 30),
					                BYTE_W'($urandom), 1'($urandom_range(0, 1)), 1'b1);
					4: send_request(ACT_PUSH, $urandom, BYTE_W'($urandom), 1'b0,
					                1'($urandom_range(0, 1)));
					default: send_read();
				endcase
			end else if (roll < 42 || (wr_head - read_pos) > 900) begin
				repeat ($urandom_range(1, 16)) send_read();
			end else if (roll < 46) begin
				// A long run pushed back to front: one push assembles it all.
				blk_len = $urandom_range(60, 200);
				push_segment(wr_head, int'(blk_len), ORD_DESCENDING);
				wr_head = wr_head + blk_len;
			end else begin
				blk_len = $urandom_range(1, 24);
				push_segment(wr_head - $urandom_range(0, 3), int'(blk_len),
				             push_order_t'($urandom_range(0, 2)));
				wr_head = wr_head + blk_len;
			end
		end
		wait_idle();

		// Fill the whole window back to front, past its end, then read part of it.
		win_base = read_pos;
		fill_bot = asm_pos;
		fill_top = read_pos + CAPACITY + 8;
		while (fill_top != fill_bot) begin
			blk_len = (fill_top - fill_bot > 32) ? 32 : fill_top - fill_bot;
			push_segment(fill_top - blk_len, int'(blk_len), ORD_ASCENDING);
			fill_top = fill_top - blk_len;
		end
		send_push(win_base + CAPACITY, BYTE_W'($urandom));
		send_push(win_base + CAPACITY - 1, BYTE_W'($urandom));
		repeat (DRAIN_READS) send_read();
		wait_idle();

		// Close the stream where it stands and read once more.
		send_request(ACT_PUSH, asm_pos, BYTE_W'($urandom), 1'b0, 1'b1);
		send_read();
		wait_idle();
		repeat (SETTLE_TICKS) @(posedge clk);

		$display("Run covered %0d requests (%0d pushes, %0d reads) in %0d cycles.",
		         n_sent, n_sent - n_reads, n_reads, cycles);
		$display("Out-of-order and overlapping segments, a full window and end marks.");
		if (mismatches == 0) begin
			$display("PASS byte_stream_reassembler");
		end else begin
			$display("FAIL byte_stream_reassembler");
		end
		$finish;
	end

endmodule
